>>> src/gelu_pkg.sv
// ----------------------------------------------------------------------------
// GELU package
// Shared word types, fixed-point constants and the 2^-f coefficient table
// for the tanh-approximation GELU pipeline.
// ----------------------------------------------------------------------------
package gelu_pkg;

    // Sample format: signed Q4.12.
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;

    // Rounding offsets for the right shifts.
    localparam int ROUND_FRAC = 1 << (FRAC_BITS - 1);
    localparam int ROUND_Q30  = 1 << 29;
    localparam int ROUND_Y    = 1 << 30;

    // Tanh saturates to one once |u| reaches 8.0.
    localparam int SAT_LIMIT = 8 << FRAC_BITS;

    // Q30 constants.
    localparam logic [31:0] Q30_ONE    = 32'h4000_0000;
    localparam logic [29:0] CONST_A    = 30'd856722024;   // sqrt(2/pi)
    localparam logic [25:0] CONST_B    = 26'd48012366;    // 0.044715
    localparam logic [31:0] CONST_L2E2 = 32'd3098164009;  // 2*log2(e)

    // Pipeline sizing.
    localparam int HORNER_STEPS = 6;
    localparam int DIV_STEPS    = 31;

    // Input word.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sample_in;
        logic                         last_in;
    } gelu_in_t;

    // Result word.
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sample_out;
        logic                         last_out;
    } gelu_out_t;

    // Per-sample sideband that travels the whole pipeline.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] mag;
        logic                  neg;
        logic                  last;
    } gelu_side_t;

    // Front end to exponential unit: m * 2*log2(e) product and saturation flag.
    typedef struct packed {
        gelu_side_t  side;
        logic        sat;
        logic [46:0] lprod;
    } gelu_front_t;

    // Exponential unit to divider: rounded dividend and divisor.
    typedef struct packed {
        gelu_side_t  side;
        logic [60:0] num;
        logic [31:0] den;
    } gelu_quot_t;

    // Divider to output stage: |tanh(u)| in Q30.
    typedef struct packed {
        gelu_side_t  side;
        logic [30:0] tanh_mag;
    } gelu_tanh_t;

    // Degree-7 polynomial for 2^-f in Q30, index 0 is the constant term.
    function automatic logic [30:0] exp2_coef(input logic [2:0] idx);
        logic [30:0] coef;
        case (idx)
            3'd0:    coef = 31'd1073741824;
            3'd1:    coef = 31'd744261118;
            3'd2:    coef = 31'd257941248;
            3'd3:    coef = 31'd59597083;
            3'd4:    coef = 31'd10327388;
            3'd5:    coef = 31'd1431680;
            3'd6:    coef = 31'd165394;
            default: coef = 31'd16378;
        endcase
        return coef;
    endfunction

endpackage

>>> src/gelu_tanh_activation_top.sv
// ----------------------------------------------------------------------------
// GELU activation, tanh approximation
// Element-wise y = 0.5*x*(1 + tanh(sqrt(2/pi)*(x + 0.044715*x^3))) on signed
// Q4.12 words, with the last flag passed through.
// ----------------------------------------------------------------------------
// The block takes one word per clock while s_ready is high and returns one
// result word per input word, in order. Forty-six register stages lie
// between the two channels: five front-end multiply stages, seven stages for
// the 2^-f Horner chain plus one that forms the divider operands, one
// quotient bit per stage in a 31-stage divider for tanh, and two output
// stages. The result sits in an output register backed by one skid word, so
// s_ready depends only on registered state and drops only after the
// downstream side has held off with a word waiting. Every stage ahead of the
// output register holds when the skid word is occupied, so nothing is lost
// or repeated.
module gelu_tanh_activation_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gelu_pkg::gelu_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gelu_pkg::gelu_out_t m_data
);

    logic                  en;
    logic                  front_valid;
    gelu_pkg::gelu_front_t front_data;
    logic                  quot_valid;
    gelu_pkg::gelu_quot_t  quot_data;
    logic                  tanh_valid;
    gelu_pkg::gelu_tanh_t  tanh_data;

    assign s_ready = en;

    // Cubic term, tanh argument and exponent scaling.
    gelu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid && en),
        .in_data   (s_data),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    // 2^-f polynomial and the tanh dividend and divisor.
    gelu_exp2 u_exp2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (quot_valid),
        .out_data  (quot_data)
    );

    // Pipelined division for |tanh|.
    gelu_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (quot_valid),
        .in_data   (quot_data),
        .out_valid (tanh_valid),
        .out_data  (tanh_data)
    );

    // Final scaling and the result channel.
    gelu_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (tanh_valid),
        .in_data  (tanh_data),
        .en       (en),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

>>> src/gelu_front.sv
// ----------------------------------------------------------------------------
// GELU front end
// Five stages from the sample to the scaled tanh argument: x^2, x^3,
// B*x^3, the argument u, and the product |u| * 2*log2(e).
// ----------------------------------------------------------------------------
module gelu_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  gelu_pkg::gelu_in_t    in_data,
    output logic                  out_valid,
    output gelu_pkg::gelu_front_t out_data
);

    localparam int DW = gelu_pkg::DATA_WIDTH;

    logic [DW-1:0]        raw;
    logic [DW-1:0]        x_abs;
    gelu_pkg::gelu_side_t side1_next, side1_reg;
    logic [31:0]          sq1_next, sq1_reg;
    gelu_pkg::gelu_side_t side2_reg;
    logic [18:0]          x2;
    logic [34:0]          cube2_next, cube2_reg;
    gelu_pkg::gelu_side_t side3_reg;
    logic [21:0]          x3;
    logic [47:0]          bprod3_next, bprod3_reg;
    gelu_pkg::gelu_side_t side4_reg;
    logic [16:0]          bx3;
    logic [17:0]          arg;
    logic [47:0]          aprod4_next, aprod4_reg;
    gelu_pkg::gelu_side_t side5_reg;
    logic [16:0]          u_mag;
    logic                 sat5_next, sat5_reg;
    logic [46:0]          lprod5_next, lprod5_reg;
    logic [4:0]           valid_reg;

    // Stage 1: magnitude and sign of x, then x*x.
    always_comb begin
        raw        = in_data.sample_in;
        x_abs      = raw[DW-1] ? (DW'(0) - raw) : raw;
        side1_next = '{mag: x_abs, neg: raw[DW-1], last: in_data.last_in};
        sq1_next   = 32'(x_abs) * 32'(x_abs);
    end

    // Stage 2: round x^2 to Q12, then multiply by |x|.
    always_comb begin
        x2         = 19'((sq1_reg + 32'(gelu_pkg::ROUND_FRAC)) >> gelu_pkg::FRAC_BITS);
        cube2_next = 35'(x2) * 35'(side1_reg.mag);
    end

    // Stage 3: round |x|^3 to Q12, then scale by B.
    always_comb begin
        x3          = 22'((cube2_reg + 35'(gelu_pkg::ROUND_FRAC)) >> gelu_pkg::FRAC_BITS);
        bprod3_next = 48'(x3) * 48'(gelu_pkg::CONST_B);
    end

    // Stage 4: x and B*x^3 share a sign, so the argument magnitude is a sum.
    always_comb begin
        bx3         = 17'((bprod3_reg + 48'(gelu_pkg::ROUND_Q30)) >> 30);
        arg         = 18'(side3_reg.mag) + 18'(bx3);
        aprod4_next = 48'(arg) * 48'(gelu_pkg::CONST_A);
    end

    // Stage 5: |u| in Q12, saturation test, and |u| * 2*log2(e).
    always_comb begin
        u_mag       = 17'((aprod4_reg + 48'(gelu_pkg::ROUND_Q30)) >> 30);
        sat5_next   = (u_mag >= 17'(gelu_pkg::SAT_LIMIT));
        lprod5_next = 47'(u_mag[14:0]) * 47'(gelu_pkg::CONST_L2E2);
    end

    // Valid bits advance with the pipeline enable.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    // Data registers need no reset.
    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg  <= side1_next;
            sq1_reg    <= sq1_next;
            side2_reg  <= side1_reg;
            cube2_reg  <= cube2_next;
            side3_reg  <= side2_reg;
            bprod3_reg <= bprod3_next;
            side4_reg  <= side3_reg;
            aprod4_reg <= aprod4_next;
            side5_reg  <= side4_reg;
            sat5_reg   <= sat5_next;
            lprod5_reg <= lprod5_next;
        end
    end

    assign out_valid = valid_reg[4];
    assign out_data  = '{side: side5_reg, sat: sat5_reg, lprod: lprod5_reg};

endmodule

>>> src/gelu_exp2.sv
// ----------------------------------------------------------------------------
// GELU exponential unit
// Splits v = |u| * 2*log2(e) into integer and fraction, evaluates 2^-f with
// a Horner chain (one step per stage), shifts by the integer part and forms
// the rounded dividend and divisor of (1 - e) / (1 + e).
// ----------------------------------------------------------------------------
module gelu_exp2 (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  gelu_pkg::gelu_front_t in_data,
    output logic                  out_valid,
    output gelu_pkg::gelu_quot_t  out_data
);

    localparam int NS = gelu_pkg::HORNER_STEPS + 1;

    typedef struct packed {
        gelu_pkg::gelu_side_t side;
        logic                 sat;
        logic [4:0]           k;
        logic [29:0]          f;
        logic [59:0]          prod;
    } horner_t;

    logic [34:0]          v;
    horner_t              h_next [NS];
    horner_t              h_reg  [NS];
    logic [NS-1:0]        h_valid_reg;
    logic [30:0]          p0;
    logic [30:0]          e;
    logic [30:0]          one_minus_e;
    logic [31:0]          den;
    gelu_pkg::gelu_quot_t q_next, q_reg;
    logic                 q_valid_reg;

    // First stage: split v and start with the highest coefficient.
    always_comb begin
        v = 35'((in_data.lprod + 47'(gelu_pkg::ROUND_FRAC)) >> gelu_pkg::FRAC_BITS);
        h_next[0].side = in_data.side;
        h_next[0].sat  = in_data.sat;
        h_next[0].k    = v[34:30];
        h_next[0].f    = v[29:0];
        h_next[0].prod = 60'(gelu_pkg::exp2_coef(3'd7)) * 60'(v[29:0]);
    end

    // Horner steps: p = c[i] - p*f/2^30, truncating; p stays positive.
    for (genvar j = 1; j < NS; j++) begin : g_horner
        logic [29:0] p;
        always_comb begin
            p = 30'(gelu_pkg::exp2_coef(3'(NS - j))) - h_reg[j-1].prod[59:30];
            h_next[j].side = h_reg[j-1].side;
            h_next[j].sat  = h_reg[j-1].sat;
            h_next[j].k    = h_reg[j-1].k;
            h_next[j].f    = h_reg[j-1].f;
            h_next[j].prod = 60'(p) * 60'(h_reg[j-1].f);
        end
    end

    // Last step, shift by k, and build (1-e)<<30 + (1+e)/2 over 1+e.
    // A saturated argument forces e to zero, which gives tanh of exactly one.
    always_comb begin
        p0          = gelu_pkg::exp2_coef(3'd0) - 31'(h_reg[NS-1].prod[59:30]);
        e           = h_reg[NS-1].sat ? 31'd0 : (p0 >> h_reg[NS-1].k);
        den         = gelu_pkg::Q30_ONE + 32'(e);
        one_minus_e = 31'(gelu_pkg::Q30_ONE) - e;
        q_next.side = h_reg[NS-1].side;
        q_next.num  = {one_minus_e, 30'd0} + 61'(den[31:1]);
        q_next.den  = den;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_valid_reg <= '0;
            q_valid_reg <= 1'b0;
        end else if (en) begin
            h_valid_reg <= {h_valid_reg[NS-2:0], in_valid};
            q_valid_reg <= h_valid_reg[NS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NS; i++) begin
                h_reg[i] <= h_next[i];
            end
            q_reg <= q_next;
        end
    end

    assign out_valid = q_valid_reg;
    assign out_data  = q_reg;

endmodule

>>> src/gelu_div.sv
// ----------------------------------------------------------------------------
// GELU divider
// Pipelined restoring divider, one quotient bit per stage, that turns the
// rounded dividend and divisor into |tanh(u)| in Q30.
// ----------------------------------------------------------------------------
module gelu_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  gelu_pkg::gelu_quot_t in_data,
    output logic                 out_valid,
    output gelu_pkg::gelu_tanh_t out_data
);

    localparam int NS = gelu_pkg::DIV_STEPS;

    typedef struct packed {
        gelu_pkg::gelu_side_t side;
        logic [30:0]          rem;
        logic [30:0]          nlo;
        logic [30:0]          quo;
        logic [31:0]          den;
    } div_stage_t;

    div_stage_t    cur       [NS];
    div_stage_t    stage_next [NS];
    div_stage_t    stage_reg  [NS];
    logic [NS-1:0] valid_reg;

    // The quotient fits in 31 bits, so the top dividend bits start below den.
    always_comb begin
        cur[0].side = in_data.side;
        cur[0].rem  = {1'b0, in_data.num[60:31]};
        cur[0].nlo  = in_data.num[30:0];
        cur[0].quo  = '0;
        cur[0].den  = in_data.den;
    end

    for (genvar j = 1; j < NS; j++) begin : g_link
        assign cur[j] = stage_reg[j-1];
    end

    // One compare and subtract per stage.
    for (genvar j = 0; j < NS; j++) begin : g_step
        logic [31:0] trial;
        logic        fits;
        always_comb begin
            trial = {cur[j].rem, cur[j].nlo[30]};
            fits  = (trial >= cur[j].den);
            stage_next[j].side = cur[j].side;
            stage_next[j].rem  = fits ? 31'(trial - cur[j].den) : trial[30:0];
            stage_next[j].nlo  = {cur[j].nlo[29:0], 1'b0};
            stage_next[j].quo  = {cur[j].quo[29:0], fits};
            stage_next[j].den  = cur[j].den;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NS; i++) begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_data  = '{side: stage_reg[NS-1].side, tanh_mag: stage_reg[NS-1].quo};

endmodule

>>> src/gelu_out.sv
// ----------------------------------------------------------------------------
// GELU output stage
// Forms 1 + tanh, scales x by it, rounds, restores the sign and presents the
// word through an output register backed by one skid word. The skid state
// also produces the pipeline enable.
// ----------------------------------------------------------------------------
module gelu_out (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  gelu_pkg::gelu_tanh_t  in_data,
    output logic                  en,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gelu_pkg::gelu_out_t   m_data
);

    localparam int DW = gelu_pkg::DATA_WIDTH;

    logic [31:0]          g;
    logic [47:0]          yprod_next, yprod_reg;
    gelu_pkg::gelu_side_t side_reg;
    logic                 y_valid_reg;
    logic [DW-1:0]        y_mag;
    gelu_pkg::gelu_out_t  result;
    logic                 take;
    logic                 incoming;
    logic                 out_valid_next, out_valid_reg;
    logic                 skid_valid_next, skid_valid_reg;
    gelu_pkg::gelu_out_t  out_data_next, out_data_reg;
    gelu_pkg::gelu_out_t  skid_data_next, skid_data_reg;

    // The pipeline moves whenever the skid word is free.
    assign en = !skid_valid_reg;

    // Scale |x| by 1 + tanh(u) in Q30; tanh carries the sign of x.
    always_comb begin
        g = in_data.side.neg ? (gelu_pkg::Q30_ONE - 32'(in_data.tanh_mag))
                             : (gelu_pkg::Q30_ONE + 32'(in_data.tanh_mag));
        yprod_next = 48'(in_data.side.mag) * 48'(g);
    end

    // Drop 31 fraction bits with rounding, then apply the sign.
    always_comb begin
        y_mag             = DW'((yprod_reg + 48'(gelu_pkg::ROUND_Y)) >> 31);
        result.sample_out = side_reg.neg ? (DW'(0) - y_mag) : y_mag;
        result.last_out   = side_reg.last;
    end

    // Output register with one skid word behind it.
    always_comb begin
        take            = out_valid_reg && m_ready;
        incoming        = y_valid_reg && en;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (take) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (incoming) begin
            if (!out_valid_reg || take) begin
                out_data_next  = result;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = result;
                skid_valid_next = 1'b1;
            end
        end else if (take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                y_valid_reg <= in_valid;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            yprod_reg <= yprod_next;
            side_reg  <= in_data.side;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

>>> src/gelu_checker.sv
// ----------------------------------------------------------------------------
// GELU port checker
// Watches the top-level ports for word conservation and for the skid-based
// flow control; attached to the top level by the bind at the end.
// ----------------------------------------------------------------------------
module gelu_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input gelu_pkg::gelu_out_t m_data
);

    logic [6:0] outstanding_next, outstanding_reg;
    logic       in_fire;
    logic       out_fire;

    // Count words accepted but not yet delivered.
    always_comb begin
        in_fire          = s_valid && s_ready;
        out_fire         = m_valid && m_ready;
        outstanding_next = outstanding_reg + 7'(in_fire) - 7'(out_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
        end else begin
            outstanding_reg <= outstanding_next;
        end
    end

    // A waiting result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // No result appears without a matching input word.
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> outstanding_reg != 7'd0)
        else $error("result word without a pending input word");

    // Input is held off only while a result is waiting at the output.
    a_stall_needs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with an empty output");

    // The input stalls only after the output was refused.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("input stalled without backpressure");

endmodule

bind gelu_tanh_activation_top gelu_checker u_checker (.*);

>>> dv/gelu_tanh_activation_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GELU tanh-approximation testbench
// Streams signed Q4.12 words through the activation pipeline under varying
// sender gaps and receiver stalls. Every accepted word is run through a
// bit-exact fixed-point GELU predictor. Each result word is compared with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------

// Holds the predicted result words in arrival order and checks each result.
class gelu_scoreboard;

    localparam int     FRAC     = 12;
    localparam longint IW_LIMIT = 64'sd140737488355327;  // 2^47 - 1
    localparam longint Q30_ONE  = 64'sd1073741824;
    localparam longint K_A      = 64'sd856722024;        // sqrt(2/pi), Q30
    localparam longint K_B      = 64'sd48012366;         // 0.044715, Q30
    localparam longint K_L2E2   = 64'sd3098164009;       // 2*log2(e), Q30

    gelu_pkg::gelu_out_t gelu_due[$];
    int mismatches;

    // Exact product, rounded shift (ties away from zero), then symmetric
    // saturation to the 48-bit internal range.
    function longint mul_round_sat(longint a, longint b, int sh);
        logic         neg;
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] prod;
        neg  = (a < 0) != (b < 0);
        ma   = (a < 0) ? -a : a;
        mb   = (b < 0) ? -b : b;
        prod = {64'd0, ma} * {64'd0, mb};
        prod = (prod + (128'd1 << (sh - 1))) >> sh;
        if (prod > 128'(IW_LIMIT)) begin
            prod = 128'(IW_LIMIT);
        end
        return neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
    endfunction

    // Coefficients of the degree-7 polynomial for 2^-f in Q30.
    function longint exp2_term(int idx);
        case (idx)
            0:       return 64'sd1073741824;
            1:       return 64'sd744261118;
            2:       return 64'sd257941248;
            3:       return 64'sd59597083;
            4:       return 64'sd10327388;
            5:       return 64'sd1431680;
            6:       return 64'sd165394;
            default: return 64'sd16378;
        endcase
    endfunction

    // Tanh of a Q12 argument, returned in Q30.
    function longint tanh_q30(longint u);
        logic [63:0] mag;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        longint      v;
        longint      f;
        longint      p;
        longint      t;
        int          k;
        int          i;
        mag = (u < 0) ? -u : u;
        if (mag >= (64'd8 << FRAC)) begin
            t = Q30_ONE;
        end else begin
            // tanh(m) = (1 - 2^-v) / (1 + 2^-v) with v = 2*log2(e)*m.
            v = mul_round_sat(longint'(mag << (30 - FRAC)), K_L2E2, 30);
            k = int'(v >>> 30);
            f = v & (Q30_ONE - 1);
            p = exp2_term(7);
            for (i = 6; i >= 0; i--) begin
                p = exp2_term(i) - ((p * f) >>> 30);
            end
            e   = 64'(p) >> k;
            num = (64'(Q30_ONE) - e) << 30;
            den = 64'(Q30_ONE) + e;
            t   = longint'((num + den / 2) / den);
        end
        return (u < 0) ? -t : t;
    endfunction

    // GELU of one input word.
    function gelu_pkg::gelu_out_t gelu_of(gelu_pkg::gelu_in_t w);
        gelu_pkg::gelu_out_t r;
        longint x;
        longint x3;
        longint arg;
        longint y;
        x   = longint'($signed(w.sample_in));
        x3  = mul_round_sat(mul_round_sat(x, x, FRAC), x, FRAC);
        arg = x + mul_round_sat(x3, K_B, 30);
        if (arg > IW_LIMIT) begin
            arg = IW_LIMIT;
        end else if (arg < -IW_LIMIT) begin
            arg = -IW_LIMIT;
        end
        y = mul_round_sat(x, Q30_ONE + tanh_q30(mul_round_sat(arg, K_A, 30)), 31);
        r.sample_out = 16'(y);
        r.last_out   = w.last_in;
        return r;
    endfunction

    function void note_sample(gelu_pkg::gelu_in_t w);
        gelu_due.push_back(gelu_of(w));
    endfunction

    function void check_result(gelu_pkg::gelu_out_t got);
        gelu_pkg::gelu_out_t want;
        if (gelu_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result word: expected none, actual %0d/%0b",
                     $time, got.sample_out, got.last_out);
            return;
        end
        want = gelu_due.pop_front();
        if (got.sample_out !== want.sample_out) begin
            mismatches++;
            $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                     $time, want.sample_out, got.sample_out);
        end
        if (got.last_out !== want.last_out) begin
            mismatches++;
            $display("%0t: last_out mismatch: expected %0b, actual %0b",
                     $time, want.last_out, got.last_out);
        end
    endfunction

endclass

module gelu_tanh_activation_top_tb;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    gelu_pkg::gelu_in_t  s_data;
    logic                m_valid;
    logic                m_ready;
    gelu_pkg::gelu_out_t m_data;

    gelu_scoreboard book = new;

    // Idle and stall odds, in percent per cycle, set per phase.
    int send_idle_pct;
    int stall_pct;
    // Cycles the receiver still has to hold off.
    int rx_hold_left;

    // Extremes, large arguments of both signs, the tanh saturation edge
    // and small inputs.
    int directed_x [23] = '{0, 1, -1, 2, -2, 32767, -32768, 32766, -32767,
                            4096, -4096, 8192, -8192, 16384, -16384,
                            19900, -19900, 20100, -20100, 409, -409,
                            24576, -24576};

    gelu_tanh_activation_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Run limit, well above the slowest legal run.
    initial begin
        #5_000_000;
        $display("[gelu_tanh_activation_top] ERROR");
        $finish;
    end

    // Receiver: long hold-offs on request, otherwise random stalls of
    // bounded length.
    initial begin
        int stall_run;
        stall_run = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_left > 0) begin
                m_ready <= 1'b0;
                rx_hold_left--;
            end else if (stall_run < 40 && $urandom_range(99) < stall_pct) begin
                m_ready <= 1'b0;
                stall_run++;
            end else begin
                m_ready <= 1'b1;
                stall_run = 0;
            end
        end
    end

    // Check every result word taken by the receiver.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            book.check_result(m_data);
        end
    end

    // Offer one word after a random gap and hold it until accepted.
    task automatic send_word(input gelu_pkg::gelu_in_t w);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        @(negedge aclk);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        book.note_sample(w);
    endtask

    // Random words: full range, the curved region within +-3.0, and the
    // neighborhood where tanh saturates.
    task automatic send_random(input int count);
        gelu_pkg::gelu_in_t w;
        int sel;
        repeat (count) begin
            sel = $urandom_range(9);
            if (sel < 5) begin
                w.sample_in = 16'($urandom);
            end else if (sel < 8) begin
                w.sample_in = 16'($urandom_range(24576)) - 16'd12288;
            end else begin
                w.sample_in = 16'($urandom_range(21000, 19000));
                if ($urandom_range(1) == 1) begin
                    w.sample_in = -w.sample_in;
                end
            end
            w.last_in = ($urandom_range(15) == 0);
            send_word(w);
        end
    endtask

    // Stop offering and wait until every predicted word has come back.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (book.gelu_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        gelu_pkg::gelu_in_t w;
        int phase;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        rx_hold_left  = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words back to back.
        foreach (directed_x[i]) begin
            w.sample_in = 16'(directed_x[i]);
            w.last_in   = 1'(i);
            send_word(w);
        end
        drain();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 88; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 88; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase
            send_random(440);
            drain();

            // Hold the receiver off while words keep coming, so the
            // pipeline fills and pushes back on the sender.
            if (phase == 0) begin
                rx_hold_left = 300;
                send_random(80);
                drain();
            end
        end

        repeat (64) @(posedge aclk);
        if (book.mismatches == 0 && book.gelu_due.size() == 0) begin
            $display("[gelu_tanh_activation_top] OK");
        end else begin
            $display("[gelu_tanh_activation_top] ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/gelu_pkg.sv
src/gelu_front.sv
src/gelu_exp2.sv
src/gelu_div.sv
src/gelu_out.sv
src/gelu_tanh_activation_top.sv
src/gelu_checker.sv
dv/gelu_tanh_activation_top_tb.sv
